// ----- rtl/rational_arithmetic_unit_assert.svh -----
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RAU_ASSERT(label, clk, rst_n, prop)
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/rau_pkg.sv -----
// -----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared payload types, codes and controller/datapath interface structs.
// -----------------------------------------------------------------------------
package rau_pkg;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ZERO_DEN = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic [62:0]        res_den;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic combine;
    logic div_start;
    logic div_step;
    logic gcd_swap;
    logic red_start;
    logic red_num;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic error;
    logic div_done;
    logic gcd_done;
  } sts_t;

endpackage

// ----- rtl/rau_ctrl.sv -----
// -----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences the product, gcd and reduction phases of the datapath.
// -----------------------------------------------------------------------------
module rau_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_busy_i,
  input  rau_pkg::sts_t sts_i,
  output rau_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MUL1, S_MUL2, S_COMB, S_GCD_START, S_GCD_DIV,
    S_GCD_SWAP, S_RED_DEN, S_RED_DEN_W, S_RED_NUM, S_RED_NUM_W, S_FINISH
  } state_e;

  state_e state_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.mul1      = (state_q == S_MUL1);
    cmd_o.mul2      = (state_q == S_MUL2);
    cmd_o.combine   = (state_q == S_COMB);
    cmd_o.div_start = (state_q == S_GCD_START) || (state_q == S_RED_DEN) ||
                      (state_q == S_RED_NUM);
    cmd_o.div_step  = (state_q == S_GCD_DIV) || (state_q == S_RED_DEN_W) ||
                      (state_q == S_RED_NUM_W);
    cmd_o.gcd_swap  = (state_q == S_GCD_SWAP);
    cmd_o.red_start = (state_q == S_RED_DEN);
    cmd_o.red_num   = (state_q == S_RED_NUM) || (state_q == S_RED_NUM_W);
    cmd_o.finish    = (state_q == S_FINISH) && !out_busy_i;
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE:      if (in_valid_i) state_q <= S_CHECK;
        S_CHECK:     state_q <= sts_i.error ? S_FINISH : S_MUL1;
        S_MUL1:      state_q <= S_MUL2;
        S_MUL2:      state_q <= S_COMB;
        S_COMB:      state_q <= S_GCD_START;
        S_GCD_START: state_q <= sts_i.gcd_done ? S_RED_DEN : S_GCD_DIV;
        S_GCD_DIV:   if (sts_i.div_done) state_q <= S_GCD_SWAP;
        S_GCD_SWAP:  state_q <= S_GCD_START;
        S_RED_DEN:   state_q <= S_RED_DEN_W;
        S_RED_DEN_W: if (sts_i.div_done) state_q <= S_RED_NUM;
        S_RED_NUM:   state_q <= S_RED_NUM_W;
        S_RED_NUM_W: if (sts_i.div_done) state_q <= S_FINISH;
        S_FINISH:    if (!out_busy_i) state_q <= S_IDLE;
        default:     state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/rau_datapath.sv -----
// -----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Operand registers, cross products, a bit-serial divider shared by the gcd
// and the reduction, and result formatting.
// -----------------------------------------------------------------------------
module rau_datapath #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic           clk_i,
  input  rau_pkg::in_t   in_i,
  input  rau_pkg::cmd_t  cmd_i,
  output rau_pkg::sts_t  sts_o,
  output rau_pkg::out_t  res_o
);

  localparam int unsigned W = OPERAND_WIDTH;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned NW = PW + 1;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [1:0]   mode_q;
  logic [W-1:0] an_q, ad_q, bn_q, bd_q;
  logic         ann_q, adn_q, bnn_q, bdn_q;
  logic [PW-1:0] p1_q, p2_q;
  logic          p1n_q, p2n_q;
  logic [NW-1:0] nm_q, dm_q, x_q, y_q;
  logic          nn_q, dn_q;
  logic [NW-1:0] quo_q, rem_q, dvd_q, dvs_q;
  logic [CW-1:0] cnt_q;
  logic          err_q;
  logic          div_busy_q;

  function automatic logic [W-1:0] mag_of(input logic [31:0] raw);
    logic [W-1:0] v;
    v = raw[W-1:0];
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic neg_of(input logic [31:0] raw);
    logic [W-1:0] v;
    v = raw[W-1:0];
    return v[W-1];
  endfunction

  logic [NW-1:0] sum;
  logic          sum_n;
  logic [NW-1:0] ea, eb;
  logic [NW:0]   trial;
  logic [NW-1:0] rem_sh;

  always_comb begin
    ea = {1'b0, p1_q};
    eb = {1'b0, p2_q};
    if (p1n_q == p2n_q) begin
      sum = ea + eb;
      sum_n = p1n_q;
    end else if (ea >= eb) begin
      sum = ea - eb;
      sum_n = p1n_q;
    end else begin
      sum = eb - ea;
      sum_n = p2n_q;
    end
    rem_sh = {rem_q[NW-2:0], dvd_q[NW-1]};
    trial = {1'b0, rem_sh} - {1'b0, dvs_q};
  end

  assign sts_o.error    = err_q;
  assign sts_o.div_done = !div_busy_q;
  assign sts_o.gcd_done = (y_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_i.mode;
      an_q <= mag_of(in_i.a_num);  ann_q <= neg_of(in_i.a_num);
      ad_q <= mag_of(in_i.a_den);  adn_q <= neg_of(in_i.a_den);
      bn_q <= mag_of(in_i.b_num);  bnn_q <= neg_of(in_i.b_num);
      bd_q <= mag_of(in_i.b_den);  bdn_q <= neg_of(in_i.b_den);
      err_q <= (mag_of(in_i.a_den) == '0) || (mag_of(in_i.b_den) == '0) ||
               ((in_i.mode == rau_pkg::MODE_DIV) && (mag_of(in_i.b_num) == '0));
    end
    if (cmd_i.mul1) begin
      if (mode_q == rau_pkg::MODE_MUL) begin
        p1_q <= PW'(an_q) * PW'(bn_q);  p1n_q <= ann_q ^ bnn_q;
      end else begin
        p1_q <= PW'(an_q) * PW'(bd_q);  p1n_q <= ann_q ^ bdn_q;
      end
      if (mode_q == rau_pkg::MODE_DIV) begin
        dm_q <= {1'b0, PW'(ad_q) * PW'(bn_q)};  dn_q <= adn_q ^ bnn_q;
      end else begin
        dm_q <= {1'b0, PW'(ad_q) * PW'(bd_q)};  dn_q <= adn_q ^ bdn_q;
      end
    end
    if (cmd_i.mul2) begin
      p2_q <= PW'(ad_q) * PW'(bn_q);
      p2n_q <= adn_q ^ bnn_q ^ (mode_q == rau_pkg::MODE_SUB);
    end
    if (cmd_i.combine) begin
      if (mode_q == rau_pkg::MODE_MUL || mode_q == rau_pkg::MODE_DIV) begin
        nm_q <= {1'b0, p1_q};  nn_q <= p1n_q;
        x_q <= {1'b0, p1_q};
      end else begin
        nm_q <= sum;  nn_q <= sum_n;
        x_q <= sum;
      end
      y_q <= dm_q;
    end
    if (cmd_i.gcd_swap) begin
      x_q <= y_q;
      y_q <= rem_q;
    end
    if (cmd_i.div_start) begin
      dvd_q <= cmd_i.red_num ? nm_q : (cmd_i.red_start ? dm_q : x_q);
      dvs_q <= cmd_i.red_start || cmd_i.red_num ? x_q : y_q;
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= CW'(NW);
      div_busy_q <= 1'b1;
    end else if (cmd_i.div_step && div_busy_q) begin
      dvd_q <= {dvd_q[NW-2:0], 1'b0};
      if (!trial[NW]) begin
        rem_q <= trial[NW-1:0];
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) div_busy_q <= 1'b0;
    end else if (!cmd_i.div_step) begin
      div_busy_q <= 1'b0;
    end
    if (cmd_i.red_num && !div_busy_q && !cmd_i.div_start) begin
      nm_q <= quo_q;
    end
    if (cmd_i.red_start) begin
      dm_q <= dm_q;
    end
    if (cmd_i.red_num && cmd_i.div_start) begin
      dm_q <= quo_q;
    end
  end

  logic          rneg;
  logic [NW-1:0] nmag;
  logic          ovf;

  always_comb begin
    nmag = nm_q;
    rneg = (nmag != '0) && (nn_q != dn_q);
    ovf = (NW > 64) && ((!rneg && nmag > NW'(64'h7FFF_FFFF_FFFF_FFFF)) ||
                        (rneg && nmag > NW'(64'h8000_0000_0000_0000)));
    res_o = '0;
    if (err_q) begin
      res_o.status = rau_pkg::STATUS_ZERO_DEN;
    end else if (ovf) begin
      res_o.status = rau_pkg::STATUS_OVERFLOW;
    end else begin
      res_o.status  = rau_pkg::STATUS_OK;
      res_o.res_num = rneg ? -64'(nmag) : 64'(nmag);
      res_o.res_den = 63'(dm_q);
    end
  end

endmodule

// ----- rtl/rational_arithmetic_unit.sv -----
// -----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two fractions, reduces the result to
// lowest terms and returns it with a positive denominator and a status.
// -----------------------------------------------------------------------------
// One transaction at a time. An item passes through the checks and the
// products, then a Euclidean gcd whose every remainder step runs through one
// bit-serial divider of 2*OPERAND_WIDTH+1 bits, then two more divisions on
// that divider for the reduction. The result is held in an output register
// until it is taken.
`include "rational_arithmetic_unit_assert.svh"
module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rau_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rau_pkg::out_t out_data_o
);

  rau_pkg::cmd_t cmd;
  rau_pkg::sts_t sts;
  rau_pkg::out_t res;
  logic          out_valid_q;
  rau_pkg::out_t out_data_q;

  rau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_busy_i (out_valid_q),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk_i (clk_i),
    .in_i  (in_data_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.finish) out_data_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `RAU_ASSERT(a_finish_free, clk_i, rst_ni, !(cmd.finish && out_valid_q))
  `RAU_ASSERT(a_no_load_busy, clk_i, rst_ni, !(cmd.load && out_valid_q && cmd.finish))
  `RAU_ASSERT_NEXT(a_finish_valid, clk_i, rst_ni, cmd.finish, out_valid_q)

endmodule
